/* hw/rtl/hid_keyboard_report_builder_defines.svh */
// Assertion macros for the keyboard report builder checker.
`ifndef HID_KEYBOARD_REPORT_BUILDER_DEFINES_SVH
`define HID_KEYBOARD_REPORT_BUILDER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define HKRB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define HKRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/hkrb_pkg.sv */
// Shared types and constants for the keyboard report builder.
package hkrb_pkg;

  localparam logic [7:0] MOD_FIRST     = 8'hE0;
  localparam logic [7:0] MOD_LAST      = 8'hE7;
  localparam logic [7:0] ROLLOVER_CODE = 8'h01;
  localparam int unsigned OUT_SLOTS    = 6;
  localparam int unsigned ROW_BITS     = 8;

  typedef struct packed {
    logic       is_key_event;
    logic [7:0] usage_code;
    logic       pressed;
  } evt_t;

  typedef struct packed {
    logic       report_changed;
    logic [7:0] modifier_byte;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
  } rpt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CHECK,
    ST_SLOTS,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    KIND_IGNORE,
    KIND_MOD,
    KIND_NOMAP,
    KIND_KEY
  } kind_t;

  typedef enum logic [2:0] {
    SLOT_NONE,
    SLOT_INSERT,
    SLOT_FILL,
    SLOT_REMOVE,
    SLOT_RESCAN
  } slot_op_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic mod_upd;
    logic map_upd;
    logic slot_upd;
    logic scan_start;
    logic scan_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_t    kind;
    logic     toggle;
    slot_op_t slot_op;
    logic     scan_done;
    logic     out_free;
  } ctrl_sts_t;

endpackage

/* hw/rtl/hkrb_ctrl.sv */
// Sequencing state machine of the keyboard report builder.
module hkrb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               evt_valid,
  output logic               evt_ready,
  input  hkrb_pkg::ctrl_sts_t sts,
  output hkrb_pkg::ctrl_cmd_t cmd
);

  hkrb_pkg::state_t state;
  hkrb_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hkrb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hkrb_pkg::ST_IDLE: begin
        if (evt_valid) state_next = hkrb_pkg::ST_LOOKUP;
      end
      hkrb_pkg::ST_LOOKUP: begin
        if (sts.kind == hkrb_pkg::KIND_KEY) state_next = hkrb_pkg::ST_CHECK;
        else state_next = hkrb_pkg::ST_EMIT;
      end
      hkrb_pkg::ST_CHECK: begin
        if (sts.toggle) state_next = hkrb_pkg::ST_SLOTS;
        else state_next = hkrb_pkg::ST_EMIT;
      end
      hkrb_pkg::ST_SLOTS: begin
        if (sts.slot_op == hkrb_pkg::SLOT_RESCAN) state_next = hkrb_pkg::ST_SCAN;
        else state_next = hkrb_pkg::ST_EMIT;
      end
      hkrb_pkg::ST_SCAN: begin
        if (sts.scan_done) state_next = hkrb_pkg::ST_EMIT;
      end
      hkrb_pkg::ST_EMIT: begin
        if (sts.out_free) state_next = hkrb_pkg::ST_IDLE;
      end
      default: begin
        state_next = hkrb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    evt_ready = 1'b0;
    case (state)
      hkrb_pkg::ST_IDLE: begin
        evt_ready   = 1'b1;
        cmd.capture = evt_valid;
      end
      hkrb_pkg::ST_LOOKUP: begin
        cmd.lookup  = (sts.kind == hkrb_pkg::KIND_KEY);
        cmd.mod_upd = (sts.kind == hkrb_pkg::KIND_MOD);
      end
      hkrb_pkg::ST_CHECK: begin
        cmd.map_upd = sts.toggle;
      end
      hkrb_pkg::ST_SLOTS: begin
        cmd.scan_start = (sts.slot_op == hkrb_pkg::SLOT_RESCAN);
        cmd.slot_upd   = (sts.slot_op != hkrb_pkg::SLOT_RESCAN);
      end
      hkrb_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      hkrb_pkg::ST_EMIT: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* hw/rtl/hkrb_dp.sv */
// Datapath: key map memory, count, slots, modifiers and report register.
module hkrb_dp #(
  parameter int unsigned KEY_SLOTS = 6,
  parameter int unsigned MAP_BITS  = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  hkrb_pkg::evt_t      evt,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                rpt_ready,
  output logic                rpt_valid,
  output hkrb_pkg::rpt_t      rpt,
  input  hkrb_pkg::ctrl_cmd_t cmd,
  output hkrb_pkg::ctrl_sts_t sts
);

  localparam int unsigned ROWS   = (MAP_BITS + hkrb_pkg::ROW_BITS - 1) / hkrb_pkg::ROW_BITS;
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned SCAN_W = $clog2(ROWS + 1);
  localparam int unsigned SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int unsigned NUM_W  = $clog2(KEY_SLOTS + 9);

  hkrb_pkg::evt_t   item;
  logic [7:0]       report_id;
  logic [7:0]       modifier_store;
  logic [8:0]       pressed_count;
  logic [7:0]       slot_store [KEY_SLOTS];
  logic [7:0]       map_mem [ROWS];
  logic [ROWS-1:0]  row_vld;
  logic [7:0]       rd_row;
  logic             rd_vld;
  logic [SCAN_W-1:0] scan_idx;
  logic             scan_pend;
  logic [ROW_W-1:0] scan_row;
  logic [NUM_W-1:0] scan_num;

  hkrb_pkg::kind_t    kind;
  hkrb_pkg::slot_op_t slot_op;
  logic [ROW_W-1:0]   item_row;
  logic [ROW_W-1:0]   rd_addr;
  logic               scan_issue;
  logic               rd_en;
  logic [7:0]         rd_eff;
  logic               cur_bit;
  logic [7:0]         row_new;
  logic [7:0]         mod_mask;
  logic [7:0]         slot_upd_v [KEY_SLOTS];
  logic [7:0]         slot_scan_v [KEY_SLOTS];
  logic [NUM_W-1:0]   scan_num_next;
  logic [7:0]         out_slot [hkrb_pkg::OUT_SLOTS];

  always_comb begin
    if (!item.is_key_event || item.usage_code == 8'd0) begin
      kind = hkrb_pkg::KIND_IGNORE;
    end else if (item.usage_code >= hkrb_pkg::MOD_FIRST &&
                 item.usage_code <= hkrb_pkg::MOD_LAST) begin
      kind = hkrb_pkg::KIND_MOD;
    end else if ({1'b0, item.usage_code} >= 9'(MAP_BITS)) begin
      kind = hkrb_pkg::KIND_NOMAP;
    end else begin
      kind = hkrb_pkg::KIND_KEY;
    end
  end

  assign item_row   = ROW_W'(item.usage_code >> 3);
  assign scan_issue = (scan_idx < SCAN_W'(ROWS));
  assign rd_en      = cmd.lookup || (cmd.scan_step && scan_issue);
  assign rd_addr    = cmd.lookup ? item_row : scan_idx[ROW_W-1:0];
  assign rd_eff     = rd_vld ? rd_row : 8'd0;
  assign cur_bit    = rd_eff[item.usage_code[2:0]];
  assign mod_mask   = 8'd1 << item.usage_code[2:0];

  always_comb begin
    row_new = rd_eff;
    row_new[item.usage_code[2:0]] = item.pressed;
  end

  always_comb begin
    if (item.pressed) begin
      if (pressed_count <= 9'(KEY_SLOTS)) slot_op = hkrb_pkg::SLOT_INSERT;
      else if (pressed_count == 9'(KEY_SLOTS + 1)) slot_op = hkrb_pkg::SLOT_FILL;
      else slot_op = hkrb_pkg::SLOT_NONE;
    end else begin
      if (pressed_count < 9'(KEY_SLOTS)) slot_op = hkrb_pkg::SLOT_REMOVE;
      else if (pressed_count == 9'(KEY_SLOTS)) slot_op = hkrb_pkg::SLOT_RESCAN;
      else slot_op = hkrb_pkg::SLOT_NONE;
    end
  end

  always_comb begin
    logic done;
    done = 1'b0;
    for (int k = 0; k < KEY_SLOTS; k++) slot_upd_v[k] = slot_store[k];
    case (slot_op)
      hkrb_pkg::SLOT_INSERT: begin
        for (int k = 0; k < KEY_SLOTS; k++) begin
          if (!done && slot_store[k] == 8'd0) begin
            slot_upd_v[k] = item.usage_code;
            done = 1'b1;
          end
        end
      end
      hkrb_pkg::SLOT_REMOVE: begin
        for (int k = 0; k < KEY_SLOTS; k++) begin
          if (!done && slot_store[k] == item.usage_code) begin
            slot_upd_v[k] = 8'd0;
            done = 1'b1;
          end
        end
      end
      hkrb_pkg::SLOT_FILL: begin
        for (int k = 0; k < KEY_SLOTS; k++) slot_upd_v[k] = hkrb_pkg::ROLLOVER_CODE;
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  always_comb begin
    logic [NUM_W-1:0] cnt;
    cnt = scan_num;
    for (int k = 0; k < KEY_SLOTS; k++) slot_scan_v[k] = slot_store[k];
    for (int b = 0; b < hkrb_pkg::ROW_BITS; b++) begin
      if (rd_eff[b]) begin
        if (cnt < NUM_W'(KEY_SLOTS)) begin
          slot_scan_v[cnt[SLOT_W-1:0]] = 8'({scan_row, 3'(b)});
        end
        cnt = cnt + NUM_W'(1);
      end
    end
    scan_num_next = (cnt > NUM_W'(KEY_SLOTS)) ? NUM_W'(KEY_SLOTS) : cnt;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item <= evt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report_id <= 8'd1;
    end else if (cfg_we) begin
      report_id <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modifier_store <= 8'd0;
    end else if (cmd.mod_upd) begin
      if (item.pressed) modifier_store <= modifier_store | mod_mask;
      else modifier_store <= modifier_store & ~mod_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.map_upd) map_mem[item_row] <= row_new;
    if (rd_en) begin
      rd_row <= map_mem[rd_addr];
      rd_vld <= row_vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld       <= '0;
      pressed_count <= 9'd0;
    end else if (cmd.map_upd) begin
      row_vld[item_row] <= 1'b1;
      if (item.pressed) pressed_count <= pressed_count + 9'd1;
      else pressed_count <= pressed_count - 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx  <= '0;
      scan_pend <= 1'b0;
      scan_num  <= '0;
    end else if (cmd.scan_start) begin
      scan_idx  <= '0;
      scan_pend <= 1'b0;
      scan_num  <= '0;
    end else if (cmd.scan_step) begin
      scan_pend <= scan_issue;
      if (scan_issue) scan_idx <= scan_idx + SCAN_W'(1);
      if (scan_pend) scan_num <= scan_num_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && scan_issue) scan_row <= scan_idx[ROW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KEY_SLOTS; k++) slot_store[k] <= 8'd0;
    end else if (cmd.scan_start) begin
      for (int k = 0; k < KEY_SLOTS; k++) slot_store[k] <= 8'd0;
    end else if (cmd.slot_upd) begin
      for (int k = 0; k < KEY_SLOTS; k++) slot_store[k] <= slot_upd_v[k];
    end else if (cmd.scan_step && scan_pend) begin
      for (int k = 0; k < KEY_SLOTS; k++) slot_store[k] <= slot_scan_v[k];
    end
  end

  for (genvar j = 0; j < hkrb_pkg::OUT_SLOTS; j++) begin : g_out
    if (j < KEY_SLOTS) begin : g_used
      assign out_slot[j] = slot_store[j];
    end else begin : g_unused
      assign out_slot[j] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rpt_valid <= 1'b1;
    end else if (rpt_ready) begin
      rpt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rpt.report_changed <= (kind != hkrb_pkg::KIND_IGNORE);
      rpt.modifier_byte  <= modifier_store;
      rpt.key_slot_0     <= out_slot[0];
      rpt.key_slot_1     <= out_slot[1];
      rpt.key_slot_2     <= out_slot[2];
      rpt.key_slot_3     <= out_slot[3];
      rpt.key_slot_4     <= out_slot[4];
      rpt.key_slot_5     <= out_slot[5];
    end
  end

  assign sts.kind      = kind;
  assign sts.toggle    = (cur_bit != item.pressed);
  assign sts.slot_op   = slot_op;
  assign sts.scan_done = !scan_issue && !scan_pend;
  assign sts.out_free  = !rpt_valid || rpt_ready;

endmodule

/* hw/rtl/hid_keyboard_report_builder.sv */
// Top level of the boot-keyboard report builder: controller plus datapath.
// Sequence: ignored, unmapped and modifier requests pass from LOOKUP to EMIT; key requests
// also pass CHECK and, if the key changes state, SLOTS; a release that leaves rollover adds
// a key map rescan, one 8-bit map row per cycle through the single memory read port.
// One request at a time: the next is accepted once the report is in the output register.
// Reset (synchronous, rst high) clears the key map row valid bits, count, slots and
// modifiers at once; report_id returns to 1.
module hid_keyboard_report_builder #(
  parameter int unsigned KEY_SLOTS = 6,
  parameter int unsigned MAP_BITS  = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           evt_valid,
  output logic           evt_ready,
  input  hkrb_pkg::evt_t evt,
  output logic           rpt_valid,
  input  logic           rpt_ready,
  output hkrb_pkg::rpt_t rpt,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata
);

  hkrb_pkg::ctrl_cmd_t cmd;
  hkrb_pkg::ctrl_sts_t sts;

  hkrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hkrb_dp #(
    .KEY_SLOTS (KEY_SLOTS),
    .MAP_BITS  (MAP_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rpt_ready (rpt_ready),
    .rpt_valid (rpt_valid),
    .rpt       (rpt),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* hw/rtl/hkrb_checker.sv */
// Port-level assertion checker for the keyboard report builder, with its bind.
`include "hid_keyboard_report_builder_defines.svh"

module hkrb_checker (
  input logic           clk,
  input logic           rst,
  input logic           evt_valid,
  input logic           evt_ready,
  input logic           rpt_valid,
  input logic           rpt_ready,
  input hkrb_pkg::rpt_t rpt
);

  `HKRB_ASSERT_NEXT(a_rpt_hold, rpt_valid && !rpt_ready, rpt_valid && $stable(rpt), "report moved")
  `HKRB_ASSERT_NEXT(a_one_at_a_time, evt_valid && evt_ready, !evt_ready, "request accepted while busy")
  `HKRB_ASSERT_NOW(a_busy_after_accept, $fell(evt_ready), $past(evt_valid), "left idle without a request")

endmodule

bind hid_keyboard_report_builder hkrb_checker u_hkrb_checker (.*);

/* verif/hid_keyboard_report_builder_test.sv */
// Self-checking testbench for the boot-keyboard report builder: directed table, then random keying.
module hid_keyboard_report_builder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_SLOTS   = 6;
  localparam int MAP_BITS    = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 325;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 40;

  typedef struct {
    hkrb_pkg::evt_t ev;
    bit             pinned;
    hkrb_pkg::rpt_t want;
  } dir_row_t;

  logic           clk;
  logic           rst = 1'b1;
  logic           evt_valid = 1'b0;
  logic           evt_ready;
  hkrb_pkg::evt_t evt = '0;
  logic           rpt_valid;
  logic           rpt_ready = 1'b0;
  hkrb_pkg::rpt_t rpt;
  logic           cfg_we = 1'b0;
  logic [7:0]     cfg_wdata = 8'h00;

  bit         held_keys [MAP_BITS];
  logic [8:0] held_count;
  logic [7:0] slot_regs [KEY_SLOTS];
  logic [7:0] mod_bits;

  hkrb_pkg::rpt_t expected_reports[$];
  hkrb_pkg::rpt_t oldest_report;
  dir_row_t       dir_rows[$];
  logic [7:0]     key_pool [12];
  int         mismatches = 0;
  int         cycles = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         hold_req = 1'b0;
  int         hold_left = 0;

  hid_keyboard_report_builder DUT (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt),
    .rpt_valid (rpt_valid),
    .rpt_ready (rpt_ready),
    .rpt       (rpt),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycles,
               expected_reports.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void press_key(logic [7:0] u);
    int k;
    bit done;
    if (held_keys[u]) return;
    held_keys[u] = 1'b1;
    held_count = held_count + 9'd1;
    if (held_count <= KEY_SLOTS) begin
      done = 1'b0;
      for (k = 0; k < KEY_SLOTS; k++) begin
        if (!done && slot_regs[k] == 8'h00) begin
          slot_regs[k] = u;
          done = 1'b1;
        end
      end
    end else if (held_count == KEY_SLOTS + 1) begin
      for (k = 0; k < KEY_SLOTS; k++) slot_regs[k] = hkrb_pkg::ROLLOVER_CODE;
    end
  endfunction

  function automatic void release_key(logic [7:0] u);
    int k;
    int n;
    bit done;
    if (!held_keys[u]) return;
    held_keys[u] = 1'b0;
    held_count = held_count - 9'd1;
    if (held_count < KEY_SLOTS) begin
      done = 1'b0;
      for (k = 0; k < KEY_SLOTS; k++) begin
        if (!done && slot_regs[k] == u) begin
          slot_regs[k] = 8'h00;
          done = 1'b1;
        end
      end
    end else if (held_count == KEY_SLOTS) begin
      n = 0;
      for (k = 0; k < KEY_SLOTS; k++) slot_regs[k] = 8'h00;
      for (int v = 0; v < MAP_BITS; v++) begin
        if (held_keys[v[7:0]] && n < KEY_SLOTS) begin
          slot_regs[n[2:0]] = v[7:0];
          n++;
        end
      end
    end
  endfunction

  function automatic hkrb_pkg::rpt_t apply_event(hkrb_pkg::evt_t e);
    hkrb_pkg::rpt_t r;
    logic [7:0] u;
    logic [7:0] mask;
    u = e.usage_code;
    r = '0;
    if (e.is_key_event && u != 8'h00) begin
      if (u >= hkrb_pkg::MOD_FIRST && u <= hkrb_pkg::MOD_LAST) begin
        mask = 8'h01 << (u - hkrb_pkg::MOD_FIRST);
        if (e.pressed) mod_bits = mod_bits | mask;
        else mod_bits = mod_bits & ~mask;
      end else if (e.pressed) begin
        press_key(u);
      end else begin
        release_key(u);
      end
      r.report_changed = 1'b1;
    end
    r.modifier_byte = mod_bits;
    r.key_slot_0 = slot_regs[0];
    r.key_slot_1 = slot_regs[1];
    r.key_slot_2 = slot_regs[2];
    r.key_slot_3 = slot_regs[3];
    r.key_slot_4 = slot_regs[4];
    r.key_slot_5 = slot_regs[5];
    return r;
  endfunction

  function automatic hkrb_pkg::evt_t mk_evt(bit k, logic [7:0] u, bit p);
    hkrb_pkg::evt_t e;
    e.is_key_event = k;
    e.usage_code = u;
    e.pressed = p;
    return e;
  endfunction

  function automatic hkrb_pkg::rpt_t mk_rpt(bit c, logic [7:0] m, logic [7:0] s0,
                                            logic [7:0] s1, logic [7:0] s2, logic [7:0] s3,
                                            logic [7:0] s4, logic [7:0] s5);
    hkrb_pkg::rpt_t r;
    r.report_changed = c;
    r.modifier_byte = m;
    r.key_slot_0 = s0;
    r.key_slot_1 = s1;
    r.key_slot_2 = s2;
    r.key_slot_3 = s3;
    r.key_slot_4 = s4;
    r.key_slot_5 = s5;
    return r;
  endfunction

  function automatic hkrb_pkg::evt_t choose_event();
    hkrb_pkg::evt_t e;
    int roll;
    int press_pct;
    int pick;
    int seen;
    roll = $urandom_range(99);
    e.is_key_event = 1'b1;
    e.pressed = 1'($urandom_range(1));
    if (roll < 8) begin
      e.is_key_event = 1'b0;
      e.usage_code = 8'($urandom_range(255));
    end else if (roll < 12) begin
      e.usage_code = 8'h00;
    end else if (roll < 27) begin
      e.usage_code = hkrb_pkg::MOD_FIRST + 8'($urandom_range(7));
    end else begin
      press_pct = held_count < 3 ? 80 : (held_count > 8 ? 20 : 55);
      e.pressed = $urandom_range(99) < press_pct;
      if (e.pressed) begin
        e.usage_code = $urandom_range(99) < 70 ? key_pool[4'($urandom_range(11))]
                                               : 8'($urandom_range(1, 255));
      end else if (held_count != 0 && $urandom_range(99) < 90) begin
        pick = $urandom_range(int'(held_count) - 1);
        seen = 0;
        for (int v = 0; v < MAP_BITS; v++) begin
          if (held_keys[v[7:0]]) begin
            if (seen == pick) e.usage_code = v[7:0];
            seen++;
          end
        end
      end else begin
        e.usage_code = 8'($urandom_range(1, 255));
      end
    end
    return e;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: %s mismatch, got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_byte(input string what, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst && rpt_valid === 1'b1 && rpt_ready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected report", rpt.modifier_byte, 8'hxx);
      end else begin
        oldest_report = expected_reports.pop_front();
        check_byte("report_changed", {7'd0, rpt.report_changed},
                   {7'd0, oldest_report.report_changed});
        check_byte("modifier_byte", rpt.modifier_byte, oldest_report.modifier_byte);
        check_byte("key_slot_0", rpt.key_slot_0, oldest_report.key_slot_0);
        check_byte("key_slot_1", rpt.key_slot_1, oldest_report.key_slot_1);
        check_byte("key_slot_2", rpt.key_slot_2, oldest_report.key_slot_2);
        check_byte("key_slot_3", rpt.key_slot_3, oldest_report.key_slot_3);
        check_byte("key_slot_4", rpt.key_slot_4, oldest_report.key_slot_4);
        check_byte("key_slot_5", rpt.key_slot_5, oldest_report.key_slot_5);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rpt_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      rpt_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rpt_ready <= 1'b0;
    end else begin
      rpt_ready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  task automatic offer(input hkrb_pkg::evt_t e, input bit pinned, input hkrb_pkg::rpt_t want);
    hkrb_pkg::rpt_t predicted;
    evt <= e;
    evt_valid <= 1'b1;
    do @(posedge clk); while (evt_ready !== 1'b1);
    predicted = apply_event(e);
    expected_reports.push_back(pinned ? want : predicted);
  endtask

  task automatic idle_sender();
    if ($urandom_range(99) < send_idle_pct) begin
      evt_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic wait_drain();
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_report_id(input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    held_count = '0;
    mod_bits = '0;
    foreach (held_keys[i]) held_keys[i] = 1'b0;
    foreach (slot_regs[i]) slot_regs[i] = 8'h00;

    dir_rows.push_back('{mk_evt(0, 8'h04, 1), 1, mk_rpt(0, 8'h00, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_evt(1, 8'h00, 1), 1, mk_rpt(0, 8'h00, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_evt(1, hkrb_pkg::MOD_FIRST, 1), 1,
                         mk_rpt(1, 8'h01, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_evt(1, hkrb_pkg::MOD_LAST, 1), 1,
                         mk_rpt(1, 8'h81, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_evt(1, 8'hFF, 1), 1, mk_rpt(1, 8'h81, 8'hFF, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_evt(1, 8'h04, 1), 0, '0});
    dir_rows.push_back('{mk_evt(1, 8'h04, 1), 0, '0});
    dir_rows.push_back('{mk_evt(1, 8'h05, 0), 0, '0});
    dir_rows.push_back('{mk_evt(1, 8'h06, 1), 0, '0});
    dir_rows.push_back('{mk_evt(1, 8'h07, 1), 0, '0});
    dir_rows.push_back('{mk_evt(1, 8'h08, 1), 0, '0});
    dir_rows.push_back('{mk_evt(1, 8'h09, 1), 0, '0});
    dir_rows.push_back('{mk_evt(1, 8'h0A, 1), 1,
                         mk_rpt(1, 8'h81, hkrb_pkg::ROLLOVER_CODE, hkrb_pkg::ROLLOVER_CODE,
                                hkrb_pkg::ROLLOVER_CODE, hkrb_pkg::ROLLOVER_CODE,
                                hkrb_pkg::ROLLOVER_CODE, hkrb_pkg::ROLLOVER_CODE)});
    dir_rows.push_back('{mk_evt(1, 8'h0B, 1), 0, '0});
    dir_rows.push_back('{mk_evt(1, 8'h04, 0), 0, '0});
    dir_rows.push_back('{mk_evt(1, 8'hFF, 0), 0, '0});
    dir_rows.push_back('{mk_evt(1, 8'h07, 0), 0, '0});
    dir_rows.push_back('{mk_evt(1, 8'h02, 1), 0, '0});
    dir_rows.push_back('{mk_evt(1, 8'h01, 1), 0, '0});
    dir_rows.push_back('{mk_evt(1, 8'h01, 0), 0, '0});
    dir_rows.push_back('{mk_evt(1, hkrb_pkg::MOD_FIRST, 0), 0, '0});
    dir_rows.push_back('{mk_evt(1, hkrb_pkg::MOD_LAST, 0), 0, '0});
    dir_rows.push_back('{mk_evt(0, hkrb_pkg::MOD_FIRST, 1), 0, '0});
    dir_rows.push_back('{mk_evt(1, 8'hDF, 1), 0, '0});
    dir_rows.push_back('{mk_evt(1, 8'hE8, 0), 0, '0});

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) offer(dir_rows[i].ev, dir_rows[i].pinned, dir_rows[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      evt_valid <= 1'b0;
      wait_drain();
      case (phase)
        0: begin
          write_report_id(8'hFF);
          send_idle_pct = 33;
          recv_stall_pct = 53;
        end
        1: begin
          write_report_id(8'($urandom_range(2, 254)));
          send_idle_pct = 53;
          recv_stall_pct = 33;
        end
        default: begin
          write_report_id(8'h01);
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      foreach (key_pool[i]) key_pool[i] = 8'($urandom_range(1, 8'hDF));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 0 && n == 100) hold_req = 1'b1;
        if (phase == 1 && n == 200) begin
          evt_valid <= 1'b0;
          wait_drain();
        end
        idle_sender();
        offer(choose_event(), 1'b0, '0);
      end
    end

    evt_valid <= 1'b0;
    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/hkrb_pkg.sv
hw/rtl/hkrb_ctrl.sv
hw/rtl/hkrb_dp.sv
hw/rtl/hid_keyboard_report_builder.sv
hw/rtl/hkrb_checker.sv
verif/hid_keyboard_report_builder_test.sv
